@@ sv/sphc_pkg.sv @@
// Shared types and constants for the stepper pulse and homing controller.
// No dependencies; used by the top level and the port checker.
package sphc_pkg;

    localparam int WINDOW_LEN = 8;
    localparam int WIN_IDX_W  = $clog2(WINDOW_LEN);
    localparam int PRE_CNT_W  = $clog2(WINDOW_LEN + 1);

    localparam int STEP_W     = 20;
    localparam int COUNT_W    = 21;
    localparam int HALF_W     = 16;
    localparam int TIMER_W    = 17;
    localparam int CFG_IDX_W  = 2;

    localparam logic [STEP_W-1:0] MAX_STEPS_RST   = 20'd55000;
    localparam logic [HALF_W-1:0] HALF_PERIOD_RST = 16'd200;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_MOVE = 2'd1;
    localparam logic [1:0] ACT_HOME = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_DIR    = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_MOVE,
        MODE_HPRE,
        MODE_HRUN
    } mode_t;

endpackage

@@ sv/stepper_pulse_homing_controller_top.sv @@
// Results: one result beat per input beat, registered on acceptance.
// Throughput: one beat per cycle; a new beat is taken whenever the output register is
// empty or drained in the same cycle, and a stalled result holds the input (all
// decisions are combinational).
// Reset (aresetn low, synchronous): idle, position and counts zero, window all
// ones, registers 55000 / 200 / 0, no result pending.
// Depends on sphc_pkg.
module stepper_pulse_homing_controller_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sphc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sphc_pkg::STEP_W-1:0]     cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_action,
    input  logic [sphc_pkg::STEP_W-1:0]     s_step_request,
    input  logic                            s_limit_level,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_pulse_out,
    output logic                            m_dir_out,
    output logic                            m_busy_res,
    output logic                            m_done_res,
    output logic [sphc_pkg::COUNT_W-1:0]    m_steps_done,
    output logic [sphc_pkg::STEP_W-1:0]     m_position
);

    // configuration
    logic [sphc_pkg::STEP_W-1:0] max_steps_reg;
    logic [sphc_pkg::HALF_W-1:0] half_period_reg;
    logic                        home_dir_reg;

    // operation state
    sphc_pkg::mode_t                mode_reg, mode_next;
    logic [sphc_pkg::STEP_W-1:0]    position_reg, position_next;
    logic [sphc_pkg::COUNT_W-1:0]   pulse_cnt_reg, pulse_cnt_next;
    logic [sphc_pkg::STEP_W-1:0]    target_reg, target_next;
    logic [sphc_pkg::TIMER_W-1:0]   timer_reg, timer_next;
    logic                           pulse_reg, pulse_next;
    logic                           dir_reg, dir_next;
    logic [sphc_pkg::WINDOW_LEN-1:0] window_reg, window_next;
    logic [sphc_pkg::PRE_CNT_W-1:0] pre_cnt_reg, pre_cnt_next;
    logic [sphc_pkg::WIN_IDX_W-1:0] wr_idx_reg, wr_idx_next;

    // result register
    logic                           m_valid_reg;
    logic                           pulse_out_reg, dir_out_reg, busy_reg, done_reg;
    logic [sphc_pkg::COUNT_W-1:0]   steps_done_reg;
    logic [sphc_pkg::STEP_W-1:0]    position_out_reg;

    logic accept, busy, tick_run, timer_run, fall_ev, decide_ev;
    logic start_move, start_home;
    logic move_ok, pre_ok, home_ok, window_any;
    logic do_move_pulse, do_presample, do_home_pulse, finish;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign busy    = (mode_reg != sphc_pkg::MODE_IDLE);

    // decision flags
    always_comb begin
        window_any = |window_reg;
        tick_run   = accept && (s_action == sphc_pkg::ACT_TICK) && busy;
        timer_run  = (timer_reg > sphc_pkg::TIMER_W'(1));
        fall_ev    = tick_run && !timer_run && pulse_reg;
        decide_ev  = tick_run && !timer_run && !pulse_reg;
        start_move = accept && (s_action == sphc_pkg::ACT_MOVE) && !busy;
        start_home = accept && (s_action == sphc_pkg::ACT_HOME) && !busy;

        move_ok = (pulse_cnt_reg < {1'b0, target_reg}) && (position_reg < max_steps_reg);
        pre_ok  = (pre_cnt_reg < sphc_pkg::PRE_CNT_W'(sphc_pkg::WINDOW_LEN));
        home_ok = (pulse_cnt_reg[sphc_pkg::COUNT_W-1:1] < max_steps_reg) && window_any;

        do_move_pulse = decide_ev && (mode_reg == sphc_pkg::MODE_MOVE) && move_ok;
        do_presample  = decide_ev && (mode_reg == sphc_pkg::MODE_HPRE) && pre_ok;
        do_home_pulse = decide_ev && home_ok &&
                        ((mode_reg == sphc_pkg::MODE_HRUN) ||
                         ((mode_reg == sphc_pkg::MODE_HPRE) && !pre_ok));
        finish        = decide_ev && !do_move_pulse && !do_presample && !do_home_pulse;
    end

    // next mode
    always_comb begin
        mode_next = mode_reg;
        priority if (start_move) begin
            mode_next = sphc_pkg::MODE_MOVE;
        end else if (start_home) begin
            mode_next = sphc_pkg::MODE_HPRE;
        end else if (finish) begin
            mode_next = sphc_pkg::MODE_IDLE;
        end else if (do_home_pulse) begin
            mode_next = sphc_pkg::MODE_HRUN;
        end else begin
            mode_next = mode_reg;
        end
    end

    // datapath next values
    always_comb begin
        position_next = position_reg;
        pulse_cnt_next = pulse_cnt_reg;
        target_next   = target_reg;
        timer_next    = timer_reg;
        pulse_next    = pulse_reg;
        dir_next      = dir_reg;
        window_next   = window_reg;
        pre_cnt_next  = pre_cnt_reg;
        wr_idx_next   = wr_idx_reg;

        if (start_move) begin
            dir_next       = ~home_dir_reg;
            target_next    = s_step_request;
            pulse_cnt_next = '0;
            timer_next     = '0;
            pulse_next     = 1'b0;
        end else if (start_home) begin
            dir_next       = home_dir_reg;
            window_next    = '1;
            pre_cnt_next   = '0;
            wr_idx_next    = '0;
            pulse_cnt_next = '0;
            timer_next     = '0;
            pulse_next     = 1'b0;
        end else if (tick_run && timer_run) begin
            timer_next = timer_reg - sphc_pkg::TIMER_W'(1);
        end else if (fall_ev) begin
            pulse_next = 1'b0;
            timer_next = {1'b0, half_period_reg};
        end else if (do_presample) begin
            window_next[pre_cnt_reg[sphc_pkg::WIN_IDX_W-1:0]] = s_limit_level;
            pre_cnt_next = pre_cnt_reg + sphc_pkg::PRE_CNT_W'(1);
            timer_next   = {half_period_reg, 1'b0};
        end else if (do_move_pulse || do_home_pulse) begin
            pulse_next     = 1'b1;
            timer_next     = {1'b0, half_period_reg};
            pulse_cnt_next = pulse_cnt_reg + sphc_pkg::COUNT_W'(1);
            if (do_move_pulse) begin
                position_next = position_reg + sphc_pkg::STEP_W'(1);
            end else begin
                window_next[wr_idx_reg] = s_limit_level;
                // wrap the write slot at the window length
                wr_idx_next = (wr_idx_reg == sphc_pkg::WIN_IDX_W'(sphc_pkg::WINDOW_LEN - 1))
                              ? '0 : wr_idx_reg + sphc_pkg::WIN_IDX_W'(1);
            end
        end else if (finish) begin
            timer_next = '0;
            if (mode_reg != sphc_pkg::MODE_MOVE) begin
                position_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_steps_reg   <= sphc_pkg::MAX_STEPS_RST;
            half_period_reg <= sphc_pkg::HALF_PERIOD_RST;
            home_dir_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sphc_pkg::REG_MAX_STEPS:   max_steps_reg   <= cfg_wdata;
                sphc_pkg::REG_HALF_PERIOD: half_period_reg <= cfg_wdata[sphc_pkg::HALF_W-1:0];
                sphc_pkg::REG_HOME_DIR:    home_dir_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= sphc_pkg::MODE_IDLE;
            position_reg  <= '0;
            pulse_cnt_reg <= '0;
            target_reg    <= '0;
            timer_reg     <= '0;
            pulse_reg     <= 1'b0;
            dir_reg       <= 1'b0;
            window_reg    <= '1;
            pre_cnt_reg   <= '0;
            wr_idx_reg    <= '0;
        end else if (accept) begin
            mode_reg      <= mode_next;
            position_reg  <= position_next;
            pulse_cnt_reg <= pulse_cnt_next;
            target_reg    <= target_next;
            timer_reg     <= timer_next;
            pulse_reg     <= pulse_next;
            dir_reg       <= dir_next;
            window_reg    <= window_next;
            pre_cnt_reg   <= pre_cnt_next;
            wr_idx_reg    <= wr_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result beat carries the state after the item
    always_ff @(posedge aclk) begin
        if (accept) begin
            pulse_out_reg    <= pulse_next;
            dir_out_reg      <= dir_next;
            busy_reg         <= (mode_next != sphc_pkg::MODE_IDLE);
            done_reg         <= finish;
            steps_done_reg   <= finish ? pulse_cnt_reg : '0;
            position_out_reg <= position_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pulse_out  = pulse_out_reg;
    assign m_dir_out    = dir_out_reg;
    assign m_busy_res   = busy_reg;
    assign m_done_res   = done_reg;
    assign m_steps_done = steps_done_reg;
    assign m_position   = position_out_reg;

endmodule

@@ sv/sphc_checker.sv @@
// Port-level checker for the stepper pulse and homing controller, bound to the top.
// Depends on sphc_pkg and stepper_pulse_homing_controller_top.
module sphc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_pulse_out,
    input logic                            m_dir_out,
    input logic                            m_busy_res,
    input logic                            m_done_res,
    input logic [sphc_pkg::COUNT_W-1:0]    m_steps_done,
    input logic [sphc_pkg::STEP_W-1:0]     m_position
);

    // a finishing beat always shows the block idle again
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done beat still reports busy");

    a_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_done_res |-> (m_steps_done == '0))
        else $error("step count without done");

    // operations end in a low phase, so an idle block never drives the step pin
    a_idle_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_busy_res |-> !m_pulse_out)
        else $error("step pin high while idle");

    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pulse_out) && $stable(m_dir_out)
            && $stable(m_position) && $stable(m_steps_done))
        else $error("stalled result changed");

endmodule

bind stepper_pulse_homing_controller_top sphc_checker u_sphc_checker (.*);

@@ bench/stepper_pulse_homing_controller_top_test.sv @@
// Self-checking bench for the stepper pulse and homing controller: random and directed
// move, homing and tick beats against a cycle-free predictor of the step logic.
// Depends on sphc_pkg and stepper_pulse_homing_controller_top.
module stepper_pulse_homing_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sphc_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [1:0]        action;
        logic [STEP_W-1:0] request;
        logic              limit;
    } motor_cmd_t;

    typedef struct {
        logic               pulse;
        logic               dir;
        logic               busy;
        logic               done;
        logic [COUNT_W-1:0] steps;
        logic [STEP_W-1:0]  pos;
    } motor_status_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [STEP_W-1:0]    cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_action = ACT_TICK;
    logic [STEP_W-1:0]    s_step_request = '0;
    logic                 s_limit_level = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_pulse_out;
    logic                 m_dir_out;
    logic                 m_busy_res;
    logic                 m_done_res;
    logic [COUNT_W-1:0]   m_steps_done;
    logic [STEP_W-1:0]    m_position;

    motor_cmd_t    pending_cmds[$];
    motor_status_t expected_status[$];
    int            src_idle_pct = 0;
    int            sink_stall_pct = 0;
    int            hold_left = 0;
    int            cycles = 0;
    int            errors = 0;
    bit            beat_taken = 1'b0;

    // Predicted controller state and register copies
    mode_t                 pm_mode;
    logic [STEP_W-1:0]     pm_position;
    logic [COUNT_W-1:0]    pm_pulses;
    logic [STEP_W-1:0]     pm_target;
    logic [TIMER_W-1:0]    pm_timer;
    logic                  pm_pulse;
    logic                  pm_dir;
    logic [WINDOW_LEN-1:0] pm_window;
    logic [PRE_CNT_W-1:0]  pm_presamples;
    logic [STEP_W-1:0]     cf_max_steps;
    logic [HALF_W-1:0]     cf_half;
    logic                  cf_home_dir;

    stepper_pulse_homing_controller_top u_dut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic motor_status_t advance_motor(input motor_cmd_t cmd);
        motor_status_t res;
        logic ended;
        logic fire;
        ended = 1'b0;
        fire = 1'b0;
        res.done = 1'b0;
        res.steps = '0;
        if (cmd.action == ACT_TICK) begin
            if (pm_mode != MODE_IDLE) begin
                if (pm_timer > 1) begin
                    pm_timer--;
                end else if (pm_pulse) begin
                    pm_pulse = 1'b0;
                    pm_timer = {1'b0, cf_half};
                end else if (pm_mode == MODE_MOVE) begin
                    if (pm_pulses < pm_target && pm_position < cf_max_steps) begin
                        fire = 1'b1;
                        pm_position++;
                    end else begin
                        ended = 1'b1;
                    end
                end else if (pm_mode == MODE_HPRE && pm_presamples < WINDOW_LEN) begin
                    pm_window[pm_presamples[WIN_IDX_W-1:0]] = cmd.limit;
                    pm_presamples++;
                    pm_timer = {cf_half, 1'b0};
                end else begin
                    // presampling is over: keep stepping while the window sees the switch
                    pm_mode = MODE_HRUN;
                    if ((pm_pulses >> 1) < cf_max_steps && |pm_window) begin
                        pm_window[pm_pulses[WIN_IDX_W-1:0]] = cmd.limit;
                        fire = 1'b1;
                    end else begin
                        pm_position = '0;
                        ended = 1'b1;
                    end
                end
            end
        end else if (pm_mode == MODE_IDLE && cmd.action == ACT_MOVE) begin
            pm_mode = MODE_MOVE;
            pm_dir = ~cf_home_dir;
            pm_target = cmd.request;
            pm_pulses = '0;
            pm_timer = '0;
            pm_pulse = 1'b0;
        end else if (pm_mode == MODE_IDLE && cmd.action == ACT_HOME) begin
            pm_mode = MODE_HPRE;
            pm_dir = cf_home_dir;
            pm_window = '1;
            pm_presamples = '0;
            pm_pulses = '0;
            pm_timer = '0;
            pm_pulse = 1'b0;
        end
        if (fire) begin
            pm_pulse = 1'b1;
            pm_timer = {1'b0, cf_half};
            pm_pulses++;
        end
        if (ended) begin
            res.done = 1'b1;
            res.steps = pm_pulses;
            pm_mode = MODE_IDLE;
            pm_timer = '0;
        end
        res.pulse = pm_pulse;
        res.dir = pm_dir;
        res.busy = (pm_mode != MODE_IDLE);
        res.pos = pm_position;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [COUNT_W-1:0] want,
                                        input logic [COUNT_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Check result beats against the oldest prediction, then predict the accepted beat.
    always @(posedge aclk) begin
        motor_status_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, got position %0h",
                             $time, m_position);
                end else begin
                    want = expected_status.pop_front();
                    check_field("pulse_out", COUNT_W'(want.pulse), COUNT_W'(m_pulse_out));
                    check_field("dir_out", COUNT_W'(want.dir), COUNT_W'(m_dir_out));
                    check_field("busy_res", COUNT_W'(want.busy), COUNT_W'(m_busy_res));
                    check_field("done_res", COUNT_W'(want.done), COUNT_W'(m_done_res));
                    check_field("steps_done", want.steps, m_steps_done);
                    check_field("position", COUNT_W'(want.pos), COUNT_W'(m_position));
                end
            end
            if (s_valid && s_ready) begin
                expected_status.push_back(
                    advance_motor('{s_action, s_step_request, s_limit_level}));
                beat_taken = 1'b1;
            end
        end
    end

    // Hold a beat until taken, then offer the next one or idle.
    always @(negedge aclk) begin
        motor_cmd_t cmd;
        if (!s_valid || beat_taken) begin
            beat_taken = 1'b0;
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                cmd = pending_cmds.pop_front();
                s_valid <= 1'b1;
                s_action <= cmd.action;
                s_step_request <= cmd.request;
                s_limit_level <= cmd.limit;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    task automatic push_cmd(input logic [1:0] action, input logic [STEP_W-1:0] request,
                            input logic limit);
        pending_cmds.push_back('{action, request, limit});
    endtask

    task automatic write_regs(input logic [STEP_W-1:0] max_steps, input logic [HALF_W-1:0] half,
                              input logic home_dir);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MAX_STEPS;
        cfg_wdata <= max_steps;
        @(negedge aclk);
        cfg_index <= REG_HALF_PERIOD;
        cfg_wdata <= STEP_W'(half);
        @(negedge aclk);
        cfg_index <= REG_HOME_DIR;
        cfg_wdata <= STEP_W'(home_dir);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cf_max_steps = max_steps;
        cf_half = half;
        cf_home_dir = home_dir;
    endtask

    task automatic settle();
        while (pending_cmds.size() != 0 || s_valid || expected_status.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One command followed by enough ticks to usually see it through.
    task automatic add_sequence(output int added);
        int eff;
        int tmax;
        int ticks;
        int lim_pct;
        int roll;
        int pick;
        logic [1:0] act;
        logic [STEP_W-1:0] req;
        eff = (cf_half == 0) ? 1 : int'(cf_half);
        tmax = 28 * eff + 4;
        if (tmax > 150) tmax = 150;
        ticks = $urandom_range(1, tmax);
        lim_pct = 10 * $urandom_range(0, 3);
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            req = STEP_W'($urandom_range(0, 6));
            // long requests only where the soft limit cuts them short
            if (cf_max_steps <= 16 && $urandom_range(0, 5) == 0) req = STEP_W'($urandom);
            push_cmd(ACT_MOVE, req, 1'($urandom_range(0, 1)));
        end else if (roll < 85) begin
            push_cmd(ACT_HOME, STEP_W'($urandom), 1'($urandom_range(0, 1)));
        end else begin
            push_cmd(ACT_NONE, STEP_W'($urandom), 1'($urandom_range(0, 1)));
        end
        for (int i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 99) < 4) begin
                pick = $urandom_range(0, 2);
                act = (pick == 0) ? ACT_MOVE : (pick == 1) ? ACT_HOME : ACT_NONE;
                push_cmd(act, STEP_W'($urandom_range(0, 6)), 1'($urandom_range(0, 1)));
            end else begin
                push_cmd(ACT_TICK, STEP_W'($urandom), $urandom_range(0, 99) < lim_pct);
            end
        end
        added = ticks + 1;
    endtask

    task automatic run_phase(input logic [STEP_W-1:0] max_steps, input logic [HALF_W-1:0] half,
                             input logic home_dir, input int src_pct, input int sink_pct,
                             input int n_items, input int hold);
        int queued;
        int added;
        write_regs(max_steps, half, home_dir);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        queued = 0;
        while (queued < n_items) begin
            add_sequence(added);
            queued += added;
        end
        @(posedge aclk);
        hold_left = hold;
        settle();
    endtask

    initial begin
        cf_max_steps = MAX_STEPS_RST;
        cf_half = HALF_PERIOD_RST;
        cf_home_dir = 1'b0;
        pm_mode = MODE_IDLE;
        pm_position = '0;
        pm_pulses = '0;
        pm_target = '0;
        pm_timer = '0;
        pm_pulse = 1'b0;
        pm_dir = 1'b0;
        pm_window = '1;
        pm_presamples = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: one-step soft limit, zero half period, inverted home direction
        write_regs(20'd1, 16'd0, 1'b1);
        push_cmd(ACT_TICK, '0, 1'b0);
        push_cmd(ACT_NONE, '1, 1'b1);
        push_cmd(ACT_MOVE, '0, 1'b0);
        push_cmd(ACT_TICK, '1, 1'b1);
        push_cmd(ACT_MOVE, '1, 1'b1);
        repeat (3) push_cmd(ACT_TICK, '0, 1'b0);
        push_cmd(ACT_HOME, 20'h5A5A5, 1'b0);
        push_cmd(ACT_MOVE, 20'h00003, 1'b0);
        push_cmd(ACT_HOME, '0, 1'b1);
        push_cmd(ACT_NONE, '0, 1'b0);
        push_cmd(ACT_TICK, '0, 1'b1);
        repeat (10) push_cmd(ACT_TICK, '1, 1'b0);
        settle();

        run_phase(20'd3, 16'd1, 1'b0, 0, 0, 220, 300);
        run_phase(20'd5, 16'd2, 1'b1, 85, 0, 200, 0);
        run_phase(20'd1, 16'd3, 1'b0, 0, 85, 200, 0);
        run_phase(20'd0, 16'd1, 1'b1, 7, 7, 180, 0);
        run_phase(20'd2, 16'd0, 1'b0, 40, 40, 200, 0);
        run_phase(20'd6, 16'd1, 1'b1, 0, 0, 220, 0);
        run_phase(20'hFFFFF, 16'd1, 1'b0, 7, 7, 200, 0);
        // slowest pulse rate last: its operation never winds down
        run_phase(20'd4, 16'hFFFF, 1'b1, 0, 0, 80, 0);

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/sphc_pkg.sv
sv/stepper_pulse_homing_controller_top.sv
sv/sphc_checker.sv
bench/stepper_pulse_homing_controller_top_test.sv
